// ----- src/lsm_pkg.sv -----
// Shared constants, codes and types of the seed-mixing bounded random generator.
package lsm_pkg;

    // Datapath widths
    localparam int SEED_W     = 64;
    localparam int HALF_W     = SEED_W / 2;
    localparam int POS_W      = 32;
    localparam int VAL_W      = 31;
    localparam int DRAW_SHIFT = 24;
    localparam int DIV_BITS   = SEED_W - DRAW_SHIFT;
    localparam int DIV_CNT_W  = $clog2(DIV_BITS);
    localparam int CFG_IDX_W  = 1;

    // Mix step constants
    localparam logic [SEED_W-1:0] MIX_MUL = 64'd6364136223846793005;
    localparam logic [SEED_W-1:0] MIX_ADD = 64'd1442695040888963407;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_SALT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_SEED = 1'b1;

    // Request codes
    localparam logic REQ_RESEED = 1'b0;
    localparam logic REQ_DRAW   = 1'b1;

    // Mix indexes that close a phase of a job
    localparam logic [2:0] BASE_LAST_MIX   = 3'd2;
    localparam logic [2:0] WORLD_LAST_MIX  = 3'd5;
    localparam logic [2:0] RESEED_LAST_MIX = 3'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_INIT,
        ST_DIV,
        ST_MOD_FIX,
        ST_MIX_A,
        ST_MIX_A_WAIT,
        ST_MIX_B,
        ST_MIX_B_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        JOB_DERIVE,
        JOB_RESEED,
        JOB_DRAW
    } t_job;

    // Operands of one multiply-add: a * b + c mod 2^64
    typedef struct packed {
        logic [SEED_W-1:0] a;
        logic [SEED_W-1:0] b;
        logic [SEED_W-1:0] c;
    } t_mul_op;

endpackage

// ----- src/lsm_mul.sv -----
// Iterative 64-bit wrapping multiply-add built on one 32x32 multiplier.
module lsm_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  lsm_pkg::t_mul_op           i_op,
    output logic                       o_done,
    output logic [lsm_pkg::SEED_W-1:0] o_result
);
    import lsm_pkg::*;

    logic [SEED_W-1:0] r_a;
    logic [SEED_W-1:0] r_b;
    logic [SEED_W-1:0] r_acc;
    logic [SEED_W-1:0] r_pp;
    logic [1:0]        r_phase;
    logic              r_busy;
    logic              r_done;

    logic [HALF_W-1:0] ma;
    logic [HALF_W-1:0] mb;
    logic [SEED_W-1:0] prod;

    // Operand halves per phase: lo*lo, lo*hi, hi*lo (hi*hi falls off the top)
    always_comb begin
        case (r_phase)
            2'd0: begin
                ma = r_a[HALF_W-1:0];
                mb = r_b[HALF_W-1:0];
            end
            2'd1: begin
                ma = r_a[HALF_W-1:0];
                mb = r_b[SEED_W-1:HALF_W];
            end
            2'd2: begin
                ma = r_a[SEED_W-1:HALF_W];
                mb = r_b[HALF_W-1:0];
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod = {{HALF_W{1'b0}}, ma} * {{HALF_W{1'b0}}, mb};

    // Sequencer: product registered, accumulated one phase later
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_a     <= i_op.a;
                    r_b     <= i_op.b;
                    r_acc   <= i_op.c;
                    r_phase <= 2'd0;
                    r_busy  <= 1'b1;
                end
            end else begin
                r_phase <= r_phase + 2'd1;
                r_pp    <= prod;
                case (r_phase)
                    2'd0: ;
                    2'd1: r_acc <= r_acc + r_pp;
                    2'd2: r_acc <= r_acc + {r_pp[HALF_W-1:0], {HALF_W{1'b0}}};
                    default: begin
                        r_acc  <= r_acc + {r_pp[HALF_W-1:0], {HALF_W{1'b0}}};
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

// ----- src/lcg_seed_mix_bounded_rng.sv -----
// Top level: seed derivation, chunk reseed and bounded draw around a shared multiplier.
// Reseed item: four mixes from accept to result.
// Draw item: bit-serial modulo, then one mix; each mix takes two multiply-adds.
// One item at a time: no new item is taken until the last result goes to the output register.
// A register write re-derives both mixed seeds; items wait meanwhile.
// Reset clears the registers and all seeds to zero, which is already consistent.
module lcg_seed_mix_bounded_rng (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic signed [lsm_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [lsm_pkg::POS_W-1:0] i_pos_z,
    input  logic [lsm_pkg::VAL_W-1:0]     i_bound,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lsm_pkg::VAL_W-1:0]     o_value,
    input  logic                          i_cfg_we,
    input  logic [lsm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lsm_pkg::SEED_W-1:0]    i_cfg_data
);
    import lsm_pkg::*;

    // Sequencer state
    t_state r_state, n_state;
    t_job   r_job, n_job;
    logic [2:0] r_idx, n_idx;
    logic   r_redo, n_redo;

    // Configuration and seeds
    logic [SEED_W-1:0] r_layer_salt, n_layer_salt;
    logic [SEED_W-1:0] r_world_seed, n_world_seed;
    logic [SEED_W-1:0] r_base, n_base;
    logic [SEED_W-1:0] r_world_mix, n_world_mix;
    logic [SEED_W-1:0] r_chunk, n_chunk;

    // Mix working registers
    logic [SEED_W-1:0] r_s, n_s;
    logic [SEED_W-1:0] r_t, n_t;

    // Item payload
    logic [POS_W-1:0] r_x, n_x;
    logic [POS_W-1:0] r_z, n_z;
    logic [VAL_W-1:0] r_bound, n_bound;

    // Modulo unit
    logic [DIV_BITS-1:0]  r_quo, n_quo;
    logic [VAL_W-1:0]     r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_neg, n_neg;
    logic [VAL_W-1:0]     r_result, n_result;

    // Output register
    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_value, n_value;

    // Multiplier link
    t_mul_op           mul_op;
    logic              mul_start;
    logic              mul_done;
    logic [SEED_W-1:0] mul_p;

    logic [SEED_W-1:0] addend;
    logic [DIV_BITS-1:0] sh;
    logic [VAL_W:0]      trial;
    logic [VAL_W:0]      trial_sub;
    logic                out_free;

    lsm_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_op     (mul_op),
        .o_done   (mul_done),
        .o_result (mul_p)
    );

    assign o_stall  = (r_state != ST_IDLE) || r_redo || i_cfg_we;
    assign o_valid  = r_out_valid;
    assign o_value  = r_value;
    assign out_free = !r_out_valid || !i_stall;

    // Addend of the current mix
    always_comb begin
        case (r_job)
            JOB_DERIVE: addend = (r_idx <= BASE_LAST_MIX) ? r_layer_salt : r_base;
            JOB_RESEED: addend = r_idx[0] ? {{(SEED_W-POS_W){r_z[POS_W-1]}}, r_z}
                                          : {{(SEED_W-POS_W){r_x[POS_W-1]}}, r_x};
            JOB_DRAW:   addend = r_world_mix;
            default:    addend = '0;
        endcase
    end

    // Multiplier operands: t = s*M + C, then s' = s*t + addend
    always_comb begin
        mul_op.a = r_s;
        if (r_state == ST_MIX_A) begin
            mul_op.b = MIX_MUL;
            mul_op.c = MIX_ADD;
        end else begin
            mul_op.b = r_t;
            mul_op.c = addend;
        end
    end

    // Draw: seed shifted right arithmetically, one restoring step per cycle
    assign sh        = r_chunk[SEED_W-1:DRAW_SHIFT];
    assign trial     = {r_rem, r_quo[DIV_BITS-1]};
    assign trial_sub = trial - {1'b0, r_bound};

    // Next state and datapath
    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_idx        = r_idx;
        n_redo       = r_redo;
        n_layer_salt = r_layer_salt;
        n_world_seed = r_world_seed;
        n_base       = r_base;
        n_world_mix  = r_world_mix;
        n_chunk      = r_chunk;
        n_s          = r_s;
        n_t          = r_t;
        n_x          = r_x;
        n_z          = r_z;
        n_bound      = r_bound;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_neg        = r_neg;
        n_result     = r_result;
        n_out_valid  = r_out_valid;
        n_value      = r_value;
        mul_start    = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (r_redo) begin
                    n_redo  = 1'b0;
                    n_job   = JOB_DERIVE;
                    n_s     = r_layer_salt;
                    n_idx   = 3'd0;
                    n_state = ST_MIX_A;
                end else if (i_valid && !o_stall) begin
                    n_x     = i_pos_x;
                    n_z     = i_pos_z;
                    n_bound = i_bound;
                    n_idx   = 3'd0;
                    if (i_req_type == REQ_RESEED) begin
                        n_job   = JOB_RESEED;
                        n_s     = r_world_mix;
                        n_state = ST_MIX_A;
                    end else begin
                        n_job   = JOB_DRAW;
                        n_state = ST_DIV_INIT;
                    end
                end
            end
            ST_DIV_INIT: begin
                n_neg   = r_chunk[SEED_W-1];
                n_quo   = r_chunk[SEED_W-1] ? (~sh + 1'b1) : sh;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = (trial >= {1'b0, r_bound}) ? trial_sub[VAL_W-1:0]
                                                   : trial[VAL_W-1:0];
                n_quo = r_quo << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_BITS - 1)) begin
                    n_state = ST_MOD_FIX;
                end
            end
            ST_MOD_FIX: begin
                if (r_bound == '0) begin
                    n_result = '0;
                end else if (r_neg && r_rem != '0) begin
                    n_result = r_bound - r_rem;
                end else begin
                    n_result = r_rem;
                end
                n_s     = r_chunk;
                n_state = ST_MIX_A;
            end
            ST_MIX_A: begin
                mul_start = 1'b1;
                n_state   = ST_MIX_A_WAIT;
            end
            ST_MIX_A_WAIT: begin
                if (mul_done) begin
                    n_t     = mul_p;
                    n_state = ST_MIX_B;
                end
            end
            ST_MIX_B: begin
                mul_start = 1'b1;
                n_state   = ST_MIX_B_WAIT;
            end
            ST_MIX_B_WAIT: begin
                if (mul_done) begin
                    n_s     = mul_p;
                    n_idx   = r_idx + 3'd1;
                    n_state = ST_MIX_A;
                    case (r_job)
                        JOB_DERIVE: begin
                            if (r_idx == BASE_LAST_MIX) begin
                                n_base = mul_p;
                                n_s    = r_world_seed;
                            end
                            if (r_idx == WORLD_LAST_MIX) begin
                                n_world_mix = mul_p;
                                n_state     = ST_IDLE;
                            end
                        end
                        JOB_RESEED: begin
                            if (r_idx == RESEED_LAST_MIX) begin
                                n_chunk  = mul_p;
                                n_result = '0;
                                n_state  = ST_DONE;
                            end
                        end
                        default: begin
                            n_chunk = mul_p;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_value     = r_result;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // Register writes restart the seed derivation
        if (i_cfg_we) begin
            n_redo = 1'b1;
            case (i_cfg_idx)
                CFG_LAYER_SALT: n_layer_salt = i_cfg_data;
                CFG_WORLD_SEED: n_world_seed = i_cfg_data;
                default:        n_redo = r_redo;
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_job        <= JOB_DERIVE;
            r_idx        <= 3'd0;
            r_redo       <= 1'b0;
            r_layer_salt <= '0;
            r_world_seed <= '0;
            r_base       <= '0;
            r_world_mix  <= '0;
            r_chunk      <= '0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_job        <= n_job;
            r_idx        <= n_idx;
            r_redo       <= n_redo;
            r_layer_salt <= n_layer_salt;
            r_world_seed <= n_world_seed;
            r_base       <= n_base;
            r_world_mix  <= n_world_mix;
            r_chunk      <= n_chunk;
            r_out_valid  <= n_out_valid;
            r_cnt        <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_s      <= n_s;
        r_t      <= n_t;
        r_x      <= n_x;
        r_z      <= n_z;
        r_bound  <= n_bound;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_neg    <= n_neg;
        r_result <= n_result;
        r_value  <= n_value;
    end

    // Checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_MIX_A_WAIT || r_state == ST_MIX_B_WAIT))
        else $error("multiplier finished outside a wait state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_MIX_A || r_state == ST_DIV_INIT))
        else $error("accepted item did not start work");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result shown without finishing an item");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_job == JOB_DRAW && r_bound != '0) |-> r_result < r_bound)
        else $error("drawn value not below bound");

endmodule

// ----- tb/lsm_checker.sv -----
`timescale 1ns / 100ps
// Checker for the seed-mixing generator: tracks the seeds, predicts each value, compares.
module lsm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_req_type,
    input  logic [lsm_pkg::POS_W-1:0]     i_pos_x,
    input  logic [lsm_pkg::POS_W-1:0]     i_pos_z,
    input  logic [lsm_pkg::VAL_W-1:0]     i_bound,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [lsm_pkg::VAL_W-1:0]     i_value,
    input  logic                          i_cfg_we,
    input  logic [lsm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lsm_pkg::SEED_W-1:0]    i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);
    import lsm_pkg::*;

    // Shadow copy of registers and seeds
    logic [SEED_W-1:0] salt_reg;
    logic [SEED_W-1:0] world_reg;
    logic [SEED_W-1:0] base_seed;
    logic [SEED_W-1:0] world_mix;
    logic [SEED_W-1:0] chunk_seed;

    // Values still owed by the block, oldest first
    logic [VAL_W-1:0]  owed_values[$];
    logic [VAL_W-1:0]  want;
    int                mismatch_count = 0;

    // One wrapping mix step: s * (s * M + C) + a
    function automatic logic [SEED_W-1:0] mix_step(input logic [SEED_W-1:0] s,
                                                   input logic [SEED_W-1:0] a);
        return s * (s * MIX_MUL + MIX_ADD) + a;
    endfunction

    // (seed >>> 24) mod limit, folded into 0..limit-1; zero limit gives 0
    function automatic logic [VAL_W-1:0] bounded_draw(input logic [SEED_W-1:0] seed,
                                                      input logic [VAL_W-1:0]  limit);
        logic [SEED_W-1:0] shifted;
        logic [SEED_W-1:0] mag;
        logic [SEED_W-1:0] rem;
        logic [SEED_W-1:0] wide_limit;
        shifted    = $signed(seed) >>> DRAW_SHIFT;
        wide_limit = {{(SEED_W-VAL_W){1'b0}}, limit};
        if (limit == '0) return '0;
        mag = seed[SEED_W-1] ? -shifted : shifted;
        rem = mag % wide_limit;
        if (seed[SEED_W-1] && rem != '0) rem = wide_limit - rem;
        return rem[VAL_W-1:0];
    endfunction

    // Base seed from the salt, then world mix seed from world seed and base
    task automatic rederive_seeds();
        logic [SEED_W-1:0] b;
        logic [SEED_W-1:0] w;
        b = salt_reg;
        repeat (3) b = mix_step(b, salt_reg);
        w = world_reg;
        repeat (3) w = mix_step(w, b);
        base_seed = b;
        world_mix = w;
    endtask

    // Advance the shadow state by one accepted item and queue its value
    task automatic take_item(input logic kind, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] z, input logic [VAL_W-1:0] limit);
        logic [SEED_W-1:0] xs;
        logic [SEED_W-1:0] zs;
        logic [SEED_W-1:0] c;
        xs = {{(SEED_W-POS_W){x[POS_W-1]}}, x};
        zs = {{(SEED_W-POS_W){z[POS_W-1]}}, z};
        if (kind == REQ_RESEED) begin
            c = world_mix;
            c = mix_step(c, xs);
            c = mix_step(c, zs);
            c = mix_step(c, xs);
            c = mix_step(c, zs);
            chunk_seed = c;
            owed_values.push_back('0);
        end else begin
            owed_values.push_back(bounded_draw(chunk_seed, limit));
            chunk_seed = mix_step(chunk_seed, world_mix);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            salt_reg   = '0;
            world_reg  = '0;
            chunk_seed = '0;
            rederive_seeds();
            owed_values.delete();
        end else begin
            // register write re-derives both mixed seeds
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LAYER_SALT: salt_reg  = i_cfg_data;
                    CFG_WORLD_SEED: world_reg = i_cfg_data;
                    default: ;
                endcase
                rederive_seeds();
            end
            if (i_in_valid && !i_in_stall) begin
                take_item(i_req_type, i_pos_x, i_pos_z, i_bound);
            end
            // compare each delivered value with the oldest one owed
            if (i_out_valid && !i_out_stall) begin
                if (owed_values.size() == 0) begin
                    $display("%0t: unexpected value: expected none, actual %0d",
                             $time, i_value);
                    mismatch_count++;
                end else begin
                    want = owed_values.pop_front();
                    if (i_value !== want) begin
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, want, i_value);
                        mismatch_count++;
                    end
                end
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= owed_values.size();
    end

endmodule

// ----- tb/tb_lcg_seed_mix_bounded_rng.sv -----
`timescale 1ns / 100ps
// Testbench top: clock, reset, item and register stimulus, receiver stalls and verdict.
module tb_lcg_seed_mix_bounded_rng;
    import lsm_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 800;
    localparam int PHASE_ITEMS   = 280;
    localparam int NUM_PHASES    = 5;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     req_type = 1'b0;
    logic signed [POS_W-1:0]  pos_x    = '0;
    logic signed [POS_W-1:0]  pos_z    = '0;
    logic [VAL_W-1:0]         bound    = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [VAL_W-1:0]         value;
    logic                     cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_idx  = CFG_LAYER_SALT;
    logic [SEED_W-1:0]        cfg_data = '0;

    logic                     idle_on  = 1'b1;
    int                       errors;
    int                       pending;
    int                       quiet_cycles = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    lcg_seed_mix_bounded_rng dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_req_type (req_type),
        .i_pos_x    (pos_x),
        .i_pos_z    (pos_z),
        .i_bound    (bound),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_value    (value),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lsm_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_req_type  (req_type),
        .i_pos_x     (pos_x),
        .i_pos_z     (pos_z),
        .i_bound     (bound),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_value     (value),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Receiver: random stalls, plus two long hold-offs that back the block up
    always begin : receiver
        int rx_cycle;
        int hold_left;
        rx_cycle  = 0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle == 20000 || rx_cycle == 50000) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = idle_on && ($urandom_range(99) < 26);
            end
        end
    end

    // Watchdog: too long without any handshake or register write
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item, entered and left at a falling edge; valid stays high after
    task automatic offer_item(input logic kind, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] z, input logic [VAL_W-1:0] limit);
        int gap;
        if (idle_on && $urandom_range(99) < 40) begin
            gap      = $urandom_range(1, 70);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        req_type = kind;
        pos_x    = x;
        pos_z    = z;
        bound    = limit;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering and wait for every owed value, then let the block settle
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write while idle; the block re-derives seeds afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEED_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
        cfg_data = {$urandom(), $urandom()};
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [POS_W-1:0] pick_coord();
        case ($urandom_range(9))
            0:       return {1'b1, {(POS_W-1){1'b0}}};
            1:       return {1'b0, {(POS_W-1){1'b1}}};
            2:       return '1;
            3, 4:    return $urandom_range(0, 64) - 32;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_bound();
        case ($urandom_range(19))
            0:              return '0;
            1, 2, 3, 4, 5:  return VAL_W'($urandom_range(1, 16));
            6, 7:           return VAL_W'({VAL_W{1'b1}} - $urandom_range(0, 15));
            8, 9:           return VAL_W'(1 << $urandom_range(0, VAL_W - 1));
            default:        return VAL_W'($urandom());
        endcase
    endfunction

    // Mostly draws, with a reseed about one item in four
    task automatic random_item();
        logic kind;
        kind = ($urandom_range(3) == 0) ? REQ_RESEED : REQ_DRAW;
        offer_item(kind, pick_coord(), pick_coord(), pick_bound());
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(negedge clk);

        // Directed items on the reset seeds: coordinate and bound extremes, zero bound
        offer_item(REQ_RESEED, 32'd0, 32'd0, VAL_W'($urandom()));
        offer_item(REQ_DRAW, $urandom(), $urandom(), 31'h7FFF_FFFF);
        offer_item(REQ_DRAW, $urandom(), $urandom(), 31'd1);
        offer_item(REQ_DRAW, $urandom(), $urandom(), 31'd0);
        offer_item(REQ_RESEED, 32'h8000_0000, 32'h8000_0000, VAL_W'($urandom()));
        offer_item(REQ_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        offer_item(REQ_DRAW, 32'd0, 32'd0, 31'd2);
        offer_item(REQ_RESEED, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        offer_item(REQ_DRAW, $urandom(), $urandom(), 31'h4000_0000);
        offer_item(REQ_DRAW, $urandom(), $urandom(), 31'd3);
        offer_item(REQ_RESEED, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0);
        offer_item(REQ_DRAW, $urandom(), $urandom(), 31'd7);
        offer_item(REQ_DRAW, $urandom(), $urandom(), 31'd0);
        offer_item(REQ_RESEED, 32'hFFFF_FFFF, 32'd0, VAL_W'($urandom()));
        offer_item(REQ_DRAW, $urandom(), $urandom(), 31'h5555_5555);
        offer_item(REQ_RESEED, 32'h5555_5555, 32'hAAAA_AAAA, VAL_W'($urandom()));
        offer_item(REQ_DRAW, $urandom(), $urandom(), 31'h2AAA_AAAA);
        offer_item(REQ_DRAW, $urandom(), $urandom(), 31'd1);
        offer_item(REQ_DRAW, $urandom(), $urandom(), 31'h7FFF_FFFE);
        offer_item(REQ_RESEED, 32'd1, 32'hFFFF_FFFF, VAL_W'($urandom()));
        offer_item(REQ_DRAW, $urandom(), $urandom(), 31'd100);

        // Random phases, each under its own register setting
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    write_reg(CFG_LAYER_SALT, 64'h7FFF_FFFF_FFFF_FFFF);
                    write_reg(CFG_WORLD_SEED, 64'h8000_0000_0000_0000);
                end
                1: begin
                    write_reg(CFG_LAYER_SALT, 64'h8000_0000_0000_0000);
                    write_reg(CFG_WORLD_SEED, 64'h7FFF_FFFF_FFFF_FFFF);
                end
                2: begin
                    write_reg(CFG_WORLD_SEED, '1);
                    write_reg(CFG_LAYER_SALT, '1);
                end
                default: begin
                    write_reg(CFG_LAYER_SALT, {$urandom(), $urandom()});
                    write_reg(CFG_WORLD_SEED, {$urandom(), $urandom()});
                end
            endcase
            // one phase runs with no idling on either side
            idle_on = (phase != 3);
            repeat (PHASE_ITEMS) random_item();
        end

        drain_results();
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/lsm_pkg.sv
src/lsm_mul.sv
src/lcg_seed_mix_bounded_rng.sv
tb/lsm_checker.sv
tb/tb_lcg_seed_mix_bounded_rng.sv
